>>> rtl/core/kdr_pkg.sv
`default_nettype none
package kdr_pkg;

  localparam int DATA_W = 32;
  localparam int PARAM_W = 16;
  localparam int ACT_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam int KEY_COUNT_DEF = 32;
  localparam int TIMER_BITS_DEF = 16;

  // item actions
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PRESS  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REPEAT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SHORT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LONG   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CHORD  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_KEYS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd4;

  localparam logic [PARAM_W-1:0] FIRST_DELAY_RST = 16'd50;
  localparam logic [PARAM_W-1:0] PERIOD_RST      = 16'd20;

  typedef struct packed {
    logic [DATA_W-1:0]  enabled_keys;
    logic [DATA_W-1:0]  active_high_keys;
    logic [DATA_W-1:0]  repeat_keys;
    logic [PARAM_W-1:0] repeat_first_delay;
    logic [PARAM_W-1:0] repeat_period;
  } kdr_cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] pin_levels;
    logic [DATA_W-1:0] query_mask;
  } kdr_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] selected_keys;
    logic [DATA_W-1:0] pending_presses;
    logic [DATA_W-1:0] debounced_keys;
  } kdr_res_t;

endpackage
`default_nettype wire

>>> rtl/core/kdr_ifs.sv
`default_nettype none
interface kdr_in_if import kdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DATA_W-1:0] pin_levels;
  logic [DATA_W-1:0] query_mask;

  modport source(output valid, output action, output pin_levels, output query_mask,
                 input ready);
  modport sink(input valid, input action, input pin_levels, input query_mask,
               output ready);
endinterface

interface kdr_out_if import kdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] selected_keys;
  logic [DATA_W-1:0] pending_presses;
  logic [DATA_W-1:0] debounced_keys;

  modport source(output valid, output selected_keys, output pending_presses,
                 output debounced_keys, input ready);
  modport sink(input valid, input selected_keys, input pending_presses,
               input debounced_keys, output ready);
endinterface

interface kdr_cfg_if import kdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kdr_cfg_regs.sv
`default_nettype none
module kdr_cfg_regs import kdr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kdr_cfg_if.sink    cfg_ch,
  output kdr_cfg_t   cfg
);

  kdr_cfg_t cfg_r;
  kdr_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ENABLED:     cfg_nxt.enabled_keys = cfg_ch.data;
        REG_ACTIVE_HIGH: cfg_nxt.active_high_keys = cfg_ch.data;
        REG_REPEAT_KEYS: cfg_nxt.repeat_keys = cfg_ch.data;
        REG_FIRST_DELAY: cfg_nxt.repeat_first_delay = cfg_ch.data[PARAM_W-1:0];
        REG_PERIOD:      cfg_nxt.repeat_period = cfg_ch.data[PARAM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled_keys       <= '0;
      cfg_r.active_high_keys   <= '0;
      cfg_r.repeat_keys        <= '0;
      cfg_r.repeat_first_delay <= FIRST_DELAY_RST;
      cfg_r.repeat_period      <= PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/kdr_state.sv
`default_nettype none
module kdr_state import kdr_pkg::*; #(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      upd,
  input  wire kdr_item_t item,
  input  wire kdr_cfg_t  cfg,
  output kdr_res_t       res
);

  // only the low 32 keys are visible through the fields
  localparam int KW = (KEY_COUNT >= DATA_W) ? DATA_W : KEY_COUNT;

  logic [KW-1:0] press_r, press_nxt;
  logic [KW-1:0] stable_r, stable_nxt;
  logic [KW-1:0] rep_r, rep_nxt;
  logic [KW-1:0] cnt_lo_r, cnt_lo_nxt;
  logic [KW-1:0] cnt_hi_r, cnt_hi_nxt;
  logic [TIMER_BITS-1:0] tmr_r, tmr_nxt;

  logic [KW-1:0] q;
  logic [KW-1:0] pins;
  logic [KW-1:0] rkeys;
  logic [KW-1:0] chg;
  logic [KW-1:0] toggle;
  logic [KW-1:0] sel;
  logic [KW-1:0] rsel;
  logic [TIMER_BITS-1:0] tmr_base;
  logic [TIMER_BITS-1:0] tmr_dec;

  assign q     = item.query_mask[KW-1:0];
  assign pins  = item.pin_levels[KW-1:0];
  assign rkeys = cfg.repeat_keys[KW-1:0];

  always_comb begin
    press_nxt  = press_r;
    stable_nxt = stable_r;
    rep_nxt    = rep_r;
    cnt_lo_nxt = cnt_lo_r;
    cnt_hi_nxt = cnt_hi_r;
    tmr_nxt    = tmr_r;
    sel        = '0;
    rsel       = '0;
    chg        = (stable_r ^ ~(pins ^ cfg.active_high_keys[KW-1:0]))
                 & cfg.enabled_keys[KW-1:0];
    toggle     = '0;
    tmr_base   = tmr_r;
    tmr_dec    = '0;

    case (item.action)
      ACT_TICK: begin
        // two-bit vertical counter, restarts wherever the sample matches
        cnt_lo_nxt = ~(cnt_lo_r & chg);
        cnt_hi_nxt = cnt_lo_nxt ^ (cnt_hi_r & chg);
        toggle     = chg & cnt_lo_nxt & cnt_hi_nxt;
        stable_nxt = stable_r ^ toggle;
        press_nxt  = press_r | (stable_nxt & toggle);
        tmr_base   = ((stable_nxt & rkeys) == '0) ?
                     TIMER_BITS'(cfg.repeat_first_delay) : tmr_r;
        tmr_dec    = tmr_base - 1'b1;
        if (tmr_dec == '0) begin
          tmr_nxt = TIMER_BITS'(cfg.repeat_period);
          rep_nxt = rep_r | (stable_nxt & rkeys);
        end else begin
          tmr_nxt = tmr_dec;
        end
      end
      ACT_PRESS: begin
        sel       = q & press_r;
        press_nxt = press_r ^ sel;
      end
      ACT_REPEAT: begin
        sel     = q & rep_r;
        rep_nxt = rep_r ^ sel;
      end
      ACT_SHORT: begin
        sel       = ~stable_r & q & press_r;
        press_nxt = press_r ^ sel;
      end
      ACT_LONG: begin
        rsel      = q & rep_r;
        rep_nxt   = rep_r ^ rsel;
        sel       = rsel & press_r;
        press_nxt = press_r ^ sel;
      end
      ACT_CHORD: begin
        // all queried keys must be pending; empty query selects nothing
        if ((press_r & q) == q) begin
          sel       = q;
          press_nxt = press_r ^ q;
        end
      end
      default: begin
        sel = '0;
      end
    endcase
  end

  assign res.selected_keys   = DATA_W'(sel);
  assign res.pending_presses = DATA_W'(press_nxt);
  assign res.debounced_keys  = DATA_W'(stable_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r  <= '0;
      stable_r <= '0;
      rep_r    <= '0;
      cnt_lo_r <= '1;
      cnt_hi_r <= '1;
      tmr_r    <= '0;
    end else if (upd) begin
      press_r  <= press_nxt;
      stable_r <= stable_nxt;
      rep_r    <= rep_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      tmr_r    <= tmr_nxt;
    end
  end

  a_query_keeps_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    upd && item.action != ACT_TICK |=> $stable(stable_r) && $stable(tmr_r)
      && $stable(cnt_lo_r) && $stable(cnt_hi_r))
    else $error("query item changed debounce state");

  a_query_sets_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    upd && item.action != ACT_TICK |=>
      (press_r & ~$past(press_r)) == '0 && (rep_r & ~$past(rep_r)) == '0)
    else $error("query item raised a flag");

  a_new_press_is_held: assert property (@(posedge clk) disable iff (!rst_n)
    upd && item.action == ACT_TICK |=> (press_r & ~$past(press_r) & ~stable_r) == '0)
    else $error("press flag latched for a released key");

  a_repeat_only_on_rkeys: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (rep_r & ~$past(rep_r) & ~($past(rkeys) & stable_r)) == '0)
    else $error("repeat flag latched for a key not held or not repeat-enabled");

endmodule
`default_nettype wire

>>> rtl/core/key_debounce_repeat_unit.sv
`default_nettype none
// Path from input accept to result valid: input register, then result register.
// One item per cycle unless the output stalls; each item's state update and result are combinational.
// Stalls: input ready drops only when both the input and result registers are full.
// Reset (rst_n low, synchronous): flags, debounced state and timer cleared, vertical
// counters all ones, registers to zero with repeat delay 50 and period 20.
module key_debounce_repeat_unit import kdr_pkg::*; #(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  kdr_in_if.sink     in_ch,
  kdr_out_if.source  out_ch,
  kdr_cfg_if.sink    cfg_ch
);

  kdr_cfg_t  cfg;
  kdr_item_t in_item_r;
  kdr_res_t  out_res_r;
  kdr_res_t  res;
  logic      in_v_r;
  logic      out_v_r;
  logic      adv;

  kdr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  kdr_state #(
    .KEY_COUNT  (KEY_COUNT),
    .TIMER_BITS (TIMER_BITS)
  ) u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // item moves from input register into result register
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.action     <= in_ch.action;
      in_item_r.pin_levels <= in_ch.pin_levels;
      in_item_r.query_mask <= in_ch.query_mask;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.selected_keys   = out_res_r.selected_keys;
  assign out_ch.pending_presses = out_res_r.pending_presses;
  assign out_ch.debounced_keys  = out_res_r.debounced_keys;

endmodule
`default_nettype wire

>>> bench/tb.sv
module tb;
  import kdr_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 360;

  logic clk;
  logic rst_n;

  kdr_in_if  in_ch();
  kdr_out_if out_ch();
  kdr_cfg_if cfg_ch();

  key_debounce_repeat_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted block state and register copy
  kdr_cfg_t          cfg_model;
  logic [DATA_W-1:0] key_press_flags;
  logic [DATA_W-1:0] key_stable;
  logic [DATA_W-1:0] key_repeat_flags;
  logic [DATA_W-1:0] vcnt_lo;
  logic [DATA_W-1:0] vcnt_hi;
  logic [15:0]       repeat_timer;

  kdr_item_t pending_items[$];
  kdr_res_t  expected_reports[$];
  kdr_item_t item_on_bus;
  kdr_res_t  want;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit drain_hold = 0;
  bit gaps_allowed = 1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [DATA_W-1:0] take_presses(input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] s;
    s = m & key_press_flags;
    key_press_flags ^= s;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] take_repeats(input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] s;
    s = m & key_repeat_flags;
    key_repeat_flags ^= s;
    return s;
  endfunction

  function automatic kdr_res_t debounce_predict(input kdr_item_t it);
    logic [DATA_W-1:0] chg;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] sel;
    kdr_res_t r;
    q = it.query_mask;
    sel = '0;
    case (it.action)
      ACT_TICK: begin
        // raw pressed level is ~(pins ^ polarity)
        chg = (key_stable ^ ~(it.pin_levels ^ cfg_model.active_high_keys))
              & cfg_model.enabled_keys;
        vcnt_lo = ~(vcnt_lo & chg);
        vcnt_hi = vcnt_lo ^ (vcnt_hi & chg);
        chg &= vcnt_lo & vcnt_hi;
        key_stable ^= chg;
        key_press_flags |= key_stable & chg;
        if ((key_stable & cfg_model.repeat_keys) == '0)
          repeat_timer = cfg_model.repeat_first_delay;
        repeat_timer = repeat_timer - 16'd1;
        if (repeat_timer == 16'd0) begin
          repeat_timer = cfg_model.repeat_period;
          key_repeat_flags |= key_stable & cfg_model.repeat_keys;
        end
      end
      ACT_PRESS:  sel = take_presses(q);
      ACT_REPEAT: sel = take_repeats(q);
      ACT_SHORT:  sel = take_presses(~key_stable & q);
      ACT_LONG:   sel = take_presses(take_repeats(q));
      ACT_CHORD:  sel = take_presses(((key_press_flags & q) == q) ? q : '0);
      default: ;
    endcase
    r.selected_keys = sel;
    r.pending_presses = key_press_flags;
    r.debounced_keys = key_stable;
    return r;
  endfunction

  task automatic queue_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] pins,
                            input logic [DATA_W-1:0] mask);
    kdr_item_t it;
    it.action = act;
    it.pin_levels = pins;
    it.query_mask = mask;
    pending_items.push_back(it);
  endtask

  function automatic kdr_item_t random_query(input logic [DATA_W-1:0] held);
    kdr_item_t it;
    it.pin_levels = $urandom;
    if ($urandom_range(0, 39) == 0)
      it.action = $urandom_range(0, 1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    else
      it.action = ACT_W'($urandom_range(ACT_PRESS, ACT_CHORD));
    case ($urandom_range(0, 9))
      0: it.query_mask = '1;
      1, 2: it.query_mask = $urandom;
      3, 4: it.query_mask = held & $urandom;
      5, 6: it.query_mask = held;
      7: it.query_mask = 32'd1 << $urandom_range(0, 31);
      8: it.query_mask = held | (32'd1 << $urandom_range(0, 31));
      default: it.query_mask = '0;
    endcase
    return it;
  endfunction

  // key patterns mostly held long enough to debounce, with short holds, glitches and queries mixed in
  task automatic queue_key_traffic(input int count, input logic [DATA_W-1:0] polarity);
    logic [DATA_W-1:0] held;
    logic [DATA_W-1:0] pins;
    int hold_ticks;
    int n;
    held = '0;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 5))
        0: held = '0;
        1: held = $urandom;
        default: begin
          held ^= 32'd1 << $urandom_range(0, 31);
          if ($urandom_range(0, 1))
            held ^= 32'd1 << $urandom_range(0, 31);
        end
      endcase
      hold_ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      repeat (hold_ticks) begin
        pins = held ^ ~polarity;
        if ($urandom_range(0, 9) == 0)
          pins ^= $urandom;
        queue_item(ACT_TICK, pins, $urandom);
        n++;
        if ($urandom_range(0, 3) == 0) begin
          pending_items.push_back(random_query(held));
          n++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_regs(input kdr_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [DATA_W-1:0]    val [5];
    idx = '{REG_ENABLED, REG_ACTIVE_HIGH, REG_REPEAT_KEYS, REG_FIRST_DELAY, REG_PERIOD};
    val = '{c.enabled_keys, c.active_high_keys, c.repeat_keys,
            DATA_W'(c.repeat_first_delay), DATA_W'(c.repeat_period)};
    @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    end
    cfg_ch.valid <= 1'b0;
    cfg_model = c;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
      drain_hold = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_reports.push_back(debounce_predict(item_on_bus));
      if (in_ch.valid && !in_ch.ready) begin
        // item still waiting, hold it
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (drain_hold && expected_reports.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item_on_bus = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= item_on_bus.action;
        in_ch.pin_levels <= item_on_bus.pin_levels;
        in_ch.query_mask <= item_on_bus.query_mask;
        drain_hold = 0;
        if (gaps_allowed && $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 18);
        if (gaps_allowed && $urandom_range(0, 299) == 0)
          drain_hold = 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: sel=%h", out_ch.selected_keys));
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.selected_keys !== want.selected_keys)
            flag_error($sformatf("selected_keys %h, want %h",
                                 out_ch.selected_keys, want.selected_keys));
          if (out_ch.pending_presses !== want.pending_presses)
            flag_error($sformatf("pending_presses %h, want %h",
                                 out_ch.pending_presses, want.pending_presses));
          if (out_ch.debounced_keys !== want.debounced_keys)
            flag_error($sformatf("debounced_keys %h, want %h",
                                 out_ch.debounced_keys, want.debounced_keys));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (gaps_allowed && $urandom_range(0, 9) == 0)
          out_stall = $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("key_debounce_repeat_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kdr_cfg_t setting;
    logic [DATA_W-1:0] keys;
    logic [DATA_W-1:0] idle_pins;

    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.pin_levels = '0;
    in_ch.query_mask = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ENABLED;
    cfg_ch.data = '0;

    cfg_model.enabled_keys = '0;
    cfg_model.active_high_keys = '0;
    cfg_model.repeat_keys = '0;
    cfg_model.repeat_first_delay = FIRST_DELAY_RST;
    cfg_model.repeat_period = PERIOD_RST;
    key_press_flags = '0;
    key_stable = '0;
    key_repeat_flags = '0;
    vcnt_lo = '1;
    vcnt_hi = '1;
    repeat_timer = '0;

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all keys disabled after reset; unused action codes change nothing
    queue_item(ACT_TICK, '1, '0);
    queue_item(ACT_UNUSED_LO, '1, '1);
    queue_item(ACT_UNUSED_HI, '0, '1);
    wait_drained();

    setting.enabled_keys = '1;
    setting.active_high_keys = 32'h0000_FFFF;
    setting.repeat_keys = 32'hFFFF_0000;
    setting.repeat_first_delay = 16'd3;
    setting.repeat_period = 16'd2;
    program_regs(setting);
    keys = 32'h8001_8001;
    idle_pins = ~setting.active_high_keys;
    // debounce on the fourth tick, first repeat on the fifth
    repeat (6) queue_item(ACT_TICK, keys ^ idle_pins, '0);
    queue_item(ACT_LONG, '0, '1);
    queue_item(ACT_REPEAT, '0, '1);
    queue_item(ACT_TICK, keys ^ idle_pins, '1);
    queue_item(ACT_REPEAT, '0, 32'h8000_0000);
    queue_item(ACT_CHORD, '1, '1);
    queue_item(ACT_CHORD, '0, 32'h0000_8000);
    repeat (4) queue_item(ACT_TICK, idle_pins, '0);
    queue_item(ACT_SHORT, '0, '1);
    queue_item(ACT_PRESS, '0, '1);
    queue_item(ACT_CHORD, '0, '0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          setting.enabled_keys = '1;
          setting.active_high_keys = '0;
          setting.repeat_keys = '1;
          setting.repeat_first_delay = 16'd1;
          setting.repeat_period = 16'd1;
        end
        1: begin
          setting.enabled_keys = $urandom | 32'h0000_00FF;
          setting.active_high_keys = $urandom;
          setting.repeat_keys = $urandom;
          setting.repeat_first_delay = 16'($urandom_range(2, 12));
          setting.repeat_period = 16'($urandom_range(1, 8));
        end
        2: begin
          setting.enabled_keys = '1;
          setting.active_high_keys = '1;
          setting.repeat_keys = $urandom;
          setting.repeat_first_delay = 16'hFFFF;
          setting.repeat_period = 16'hFFFF;
        end
        3: begin
          // zero delay and period: timer wraps, no repeat latch in this phase
          setting.enabled_keys = $urandom;
          setting.active_high_keys = $urandom;
          setting.repeat_keys = '1;
          setting.repeat_first_delay = 16'd0;
          setting.repeat_period = 16'd0;
        end
        default: begin
          setting.enabled_keys = '1;
          setting.active_high_keys = $urandom;
          setting.repeat_keys = $urandom;
          setting.repeat_first_delay = 16'($urandom_range(2, 6));
          setting.repeat_period = 16'($urandom_range(1, 4));
          gaps_allowed = 0;
        end
      endcase
      program_regs(setting);
      queue_key_traffic(PHASE_ITEMS, setting.active_high_keys);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("key_debounce_repeat_unit verification clean");
    end else begin
      $display("key_debounce_repeat_unit verification failed");
    end
    $finish;
  end

endmodule
